>>> rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the fixed-point ALU
// Operation codes, the command and response transfer structs, default
// fraction width.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_GT   = 4'd4,
    OP_LT   = 4'd5,
    OP_GE   = 4'd6,
    OP_LE   = 4'd7,
    OP_EQ   = 4'd8,
    OP_NE   = 4'd9,
    OP_MAX  = 4'd10,
    OP_MIN  = 4'd11,
    OP_INC  = 4'd12,
    OP_DEC  = 4'd13,
    OP_FINT = 4'd14,
    OP_TINT = 4'd15
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic               divide_by_zero;
  } rsp_t;

endpackage

>>> rtl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu: pipelined signed 32-bit fixed-point ALU
// Add/sub/mul/div, comparisons, max/min, inc/dec and integer conversion,
// with one restoring-divider stage per quotient bit.
// ----------------------------------------------------------------------------
//  channel | signals            | direction | transfer
//  command | start, busy, cmd   | in        | start high and busy low
//  result  | done, rsp          | out       | done high, one cycle, no stall
//
//  Every operation runs through all pipeline stages; one command may be
//  taken every cycle. The divider sets the depth: 32 + FRAC_BITS stages, one
//  quotient bit each. busy is always low, as the receiver cannot stall.
//  Reset clears all valid bits; items in flight are dropped.
module fixed_point_alu #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  fpa_pkg::cmd_t cmd,
  output logic          done,
  output fpa_pkg::rsp_t rsp
);

  localparam int QW  = 32 + FRAC_BITS;
  localparam int LAT = QW + 3;

  // Input register
  logic          v0;
  fpa_pkg::cmd_t c0;

  // Divider and side-channel stages, index = bits done
  logic              vld  [0:QW];
  fpa_pkg::op_t      opk  [0:QW];
  logic [31:0]       valk [0:QW];
  logic              cmpk [0:QW];
  logic              dzk  [0:QW];
  logic              negk [0:QW];
  logic [31:0]       remk [0:QW];
  logic [QW-1:0]     dqk  [0:QW];
  logic [31:0]       dk   [0:QW];
  logic signed [63:0] prod;

  // Stage 1 combinational results
  logic [31:0]   s1_val;
  logic          s1_cmp;
  logic          s1_dz;
  logic [31:0]   s1_absa;
  logic [31:0]   s1_absb;
  logic signed [31:0] a0;
  logic signed [31:0] b0;

  assign busy = 1'b0;
  assign a0   = c0.operand_a;
  assign b0   = c0.operand_b;

  // Capture the command
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    c0 <= cmd;
  end

  // Simple operations and divider set-up
  always_comb begin
    s1_val  = '0;
    s1_cmp  = 1'b0;
    s1_dz   = 1'b0;
    s1_absa = a0[31] ? 32'(-a0) : 32'(a0);
    s1_absb = b0[31] ? 32'(-b0) : 32'(b0);
    case (c0.operation)
      fpa_pkg::OP_ADD:  s1_val = 32'(a0 + b0);
      fpa_pkg::OP_SUB:  s1_val = 32'(a0 - b0);
      fpa_pkg::OP_DIV:  s1_dz  = (b0 == 32'sd0);
      fpa_pkg::OP_GT:   s1_cmp = a0 > b0;
      fpa_pkg::OP_LT:   s1_cmp = a0 < b0;
      fpa_pkg::OP_GE:   s1_cmp = a0 >= b0;
      fpa_pkg::OP_LE:   s1_cmp = a0 <= b0;
      fpa_pkg::OP_EQ:   s1_cmp = a0 == b0;
      fpa_pkg::OP_NE:   s1_cmp = a0 != b0;
      fpa_pkg::OP_MAX:  s1_val = (a0 > b0) ? a0 : b0;
      fpa_pkg::OP_MIN:  s1_val = (a0 < b0) ? a0 : b0;
      fpa_pkg::OP_INC:  s1_val = 32'(a0 + 32'sd1);
      fpa_pkg::OP_DEC:  s1_val = 32'(a0 - 32'sd1);
      fpa_pkg::OP_FINT: s1_val = a0 << FRAC_BITS;
      fpa_pkg::OP_TINT: s1_val = a0 >>> FRAC_BITS;
      default:          s1_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    opk[0]  <= c0.operation;
    valk[0] <= s1_val;
    cmpk[0] <= s1_cmp;
    dzk[0]  <= s1_dz;
    negk[0] <= a0[31] ^ b0[31];
    remk[0] <= '0;
    dqk[0]  <= {s1_absa, {FRAC_BITS{1'b0}}};
    dk[0]   <= s1_absb;
    prod    <= 64'(a0 * b0);
  end

  // Restoring divider stages, one quotient bit each
  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [32:0] sh;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] val_in;

    assign sh   = {remk[k-1], dqk[k-1][QW-1]};
    assign diff = sh - {1'b0, dk[k-1]};
    assign ge   = sh >= {1'b0, dk[k-1]};

    // Merge the shifted product at the first divider stage
    if (k == 1) begin : g_mul
      logic signed [63:0] psh;
      assign psh    = prod >>> FRAC_BITS;
      assign val_in = (opk[0] == fpa_pkg::OP_MUL) ? psh[31:0] : valk[0];
    end else begin : g_pass
      assign val_in = valk[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      opk[k]  <= opk[k-1];
      valk[k] <= val_in;
      cmpk[k] <= cmpk[k-1];
      dzk[k]  <= dzk[k-1];
      negk[k] <= negk[k-1];
      dk[k]   <= dk[k-1];
      remk[k] <= ge ? diff[31:0] : sh[31:0];
      dqk[k]  <= {dqk[k-1][QW-2:0], ge};
    end
  end

  // Output register: sign the quotient, select the result
  logic [31:0] qsel;
  assign qsel = dzk[QW] ? 32'd0 :
                (negk[QW] ? 32'(-dqk[QW][31:0]) : dqk[QW][31:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    rsp.result_value   <= (opk[QW] == fpa_pkg::OP_DIV) ? qsel : valk[QW];
    rsp.compare_true   <= cmpk[QW];
    rsp.divide_by_zero <= dzk[QW];
  end

  // Every transfer comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("command transfer without result");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.divide_by_zero) |-> (rsp.result_value == 32'sd0))
    else $error("divide by zero with non-zero result");

  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.compare_true) |-> (rsp.result_value == 32'sd0 && !rsp.divide_by_zero))
    else $error("comparison with value or flag set");

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the pipelined fixed-point ALU
// Drives directed and random commands with random idle gaps, predicts each
// response from the operands, and checks responses in order of transfer.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;

  localparam int FRAC     = FRAC_BITS_DEF;
  localparam int LATENCY  = FRAC + 35;
  localparam int N_RANDOM = 1250;
  localparam int LIMIT    = 400000;

  // Scoreboard: predicts responses and checks them against the DUT
  class alu_scoreboard;
    rsp_t pending[$];
    int   mismatches;

    function rsp_t predict(cmd_t c);
      rsp_t        r;
      logic signed [63:0] a, b, p, q;
      r = '0;
      a = 64'(c.operand_a);
      b = 64'(c.operand_b);
      case (c.operation)
        OP_ADD:  r.result_value = c.operand_a + c.operand_b;
        OP_SUB:  r.result_value = c.operand_a - c.operand_b;
        OP_MUL: begin
          p = a * b;
          p = p >>> FRAC;
          r.result_value = p[31:0];
        end
        OP_DIV: begin
          if (b == 0) r.divide_by_zero = 1'b1;
          else begin
            q = (a <<< FRAC) / b;
            r.result_value = q[31:0];
          end
        end
        OP_GT:   r.compare_true = a > b;
        OP_LT:   r.compare_true = a < b;
        OP_GE:   r.compare_true = a >= b;
        OP_LE:   r.compare_true = a <= b;
        OP_EQ:   r.compare_true = a == b;
        OP_NE:   r.compare_true = a != b;
        OP_MAX:  r.result_value = (a > b) ? c.operand_a : c.operand_b;
        OP_MIN:  r.result_value = (a < b) ? c.operand_a : c.operand_b;
        OP_INC:  r.result_value = c.operand_a + 32'sd1;
        OP_DEC:  r.result_value = c.operand_a - 32'sd1;
        OP_FINT: r.result_value = c.operand_a <<< FRAC;
        default: r.result_value = c.operand_a >>> FRAC;
      endcase
      return r;
    endfunction

    function void note_command(cmd_t c);
      pending.push_back(predict(c));
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected val %0d cmp %b dz %b, got val %0d cmp %b dz %b",
                   want.result_value, want.compare_true, want.divide_by_zero,
                   got.result_value, got.compare_true, got.divide_by_zero);
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done;
  cmd_t cmd;
  rsp_t rsp;
  alu_scoreboard sb;
  int   cycles;

  fixed_point_alu #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .rsp(rsp)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Check each response transfer at the rising edge
  always @(posedge clk) begin
    if (!rst && done) sb.check_response(rsp);
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Pick an operand: mostly random, often an edge value
  function logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'h100 : 32'hffff_ff00;
      4: return $signed($urandom_range(0, 2047)) - 1024;
      default: return $urandom;
    endcase
  endfunction

  function int pick_gap();
    case ($urandom_range(0, 19))
      0:       return $urandom_range(10, 60);
      1, 2, 3: return $urandom_range(1, 4);
      default: return 0;
    endcase
  endfunction

  // Hold a command until its transfer, then idle for the given gap
  task automatic send_command(op_t op, logic [31:0] a, logic [31:0] b, int gap);
    start <= 1'b1;
    cmd   <= '{operation: op, operand_a: a, operand_b: b};
    do @(posedge clk); while (busy);
    sb.note_command(cmd);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      cmd   <= '{operation: op_t'($urandom), operand_a: $urandom, operand_b: $urandom};
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    logic [31:0] edges[4];
    int i;
    sb     = new();
    cycles = 0;
    rst    = 1'b1;
    start  = 1'b0;
    cmd    = '0;
    edges  = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: every operation once on extremes, divide by zero, equal max/min
    for (i = 0; i < 16; i++)
      send_command(op_t'(i), edges[i % 4], edges[(i + 1) % 4], 0);
    send_command(OP_DIV, 32'h0000_0300, 32'h0, 1);
    send_command(OP_DIV, 32'h8000_0000, 32'hffff_ffff, 0);
    send_command(OP_DIV, 32'hffff_fd00, 32'h0000_0200, 0);
    send_command(OP_MAX, 32'h0000_1234, 32'h0000_1234, 0);
    send_command(OP_MIN, 32'hffff_0000, 32'hffff_0000, 2);
    send_command(OP_MUL, 32'h8000_0000, 32'h8000_0000, 0);
    send_command(OP_TINT, 32'hffff_ff01, 32'h0, 0);

    // Random commands with random idle gaps
    for (i = 0; i < N_RANDOM; i++)
      send_command(op_t'($urandom_range(0, 15)), pick_operand(),
                   ($urandom_range(0, 7) == 0) ? 32'h0 : pick_operand(), pick_gap());

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
